// ===== rtl/sisc_pkg.sv =====
package sisc_pkg;

    localparam int MAX_DIM   = 16;
    localparam int IDX_W     = 4;
    localparam int DIM_W     = 5;
    localparam int VAL_W     = 32;
    localparam int ACC_W     = 64;
    localparam int FRAC_BITS = 16;
    localparam int ADDR_W    = 4;
    localparam int MEM_AW    = 2 * IDX_W;
    // quotient bits: 64 integer plus 16 fraction
    localparam int DIV_STEPS = ACC_W + FRAC_BITS;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic signed [ACC_W-1:0] t_acc;

    typedef enum logic [1:0] {
        ACT_MATRIX    = 2'd0,
        ACT_RHS       = 2'd1,
        ACT_START_VEC = 2'd2,
        ACT_SOLVE     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_CONVERGED = 2'd0,
        STAT_LIMIT     = 2'd1,
        STAT_BREAKDOWN = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_DIMENSION  = 2'd0,
        REG_MAX_ITER   = 2'd1,
        REG_ALGORITHM  = 2'd2,
        REG_STOP_SHIFT = 2'd3
    } t_reg;

    // shared multiply-accumulate control
    typedef struct packed {
        logic acc_en;
        logic acc_clr;
    } t_mac_ctl;

    // divider request and response
    typedef struct packed {
        logic start;
        t_acc num;
        t_acc den;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_val quo;
    } t_div_rsp;

    // saturate a 64-bit value to the value width
    function automatic t_val sat_val(input t_acc v);
        t_acc hi;
        t_acc lo;
        hi = t_acc'({1'b0, {(VAL_W-1){1'b1}}});
        lo = -hi - t_acc'(1);
        if (v > hi) begin
            sat_val = t_val'(hi);
        end else if (v < lo) begin
            sat_val = t_val'(lo);
        end else begin
            sat_val = t_val'(v);
        end
    endfunction

    // 64-bit add with saturation
    function automatic t_acc sat_add(input t_acc a, input t_acc b);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

    // Q32.32 product back to Q16.16, floor and saturate
    function automatic t_val q_scale(input t_acc p);
        q_scale = sat_val(p >>> FRAC_BITS);
    endfunction

endpackage

// ===== rtl/sisc_in_if.sv =====
interface sisc_in_if;
    import sisc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              action;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, action, row, col, value, input ready);
    modport sink   (input valid, action, row, col, value, output ready);
endinterface

// ===== rtl/sisc_out_if.sv =====
interface sisc_out_if;
    import sisc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] solution;
    logic [7:0]              iterations;
    logic [1:0]              status;
    logic                    last;

    modport source (output valid, index, solution, iterations, status, last, input ready);
    modport sink   (input valid, index, solution, iterations, status, last, output ready);
endinterface

// ===== rtl/sisc_mac.sv =====
module sisc_mac
    import sisc_pkg::*;
(
    input  logic     i_clk,
    input  t_val     i_a,
    input  t_val     i_b,
    input  t_mac_ctl i_ctl,
    output t_acc     o_prod,
    output t_acc     o_acc
);

    t_acc r_prod;
    t_acc r_acc;

    // registered product, then saturating accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= t_acc'(i_a) * t_acc'(i_b);
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= sat_add(r_acc, r_prod);
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

// ===== rtl/sisc_div.sv =====
module sisc_div
    import sisc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                     r_busy;
    logic                     r_done;
    logic [DIV_CW-1:0]        r_cnt;
    logic [DIV_STEPS-1:0]     r_dvd;
    logic [DIV_STEPS-1:0]     r_q;
    logic [ACC_W-1:0]         r_rem;
    logic [ACC_W-1:0]         r_ud;
    logic                     r_neg;

    logic [ACC_W:0]           n_trial;
    logic [ACC_W-1:0]         n_un;
    logic [ACC_W-1:0]         n_ud;
    logic [DIV_STEPS-1:0]     n_lim;
    logic [VAL_W-1:0]         n_mag;

    // one restoring step per cycle
    always_comb begin
        n_trial = {r_rem, r_dvd[DIV_STEPS-1]};
        n_un    = i_req.num[ACC_W-1] ? ACC_W'(-i_req.num) : ACC_W'(i_req.num);
        n_ud    = i_req.den[ACC_W-1] ? ACC_W'(-i_req.den) : ACC_W'(i_req.den);
        n_lim   = r_neg ? DIV_STEPS'({1'b1, {(VAL_W-1){1'b0}}})
                        : DIV_STEPS'({1'b0, {(VAL_W-1){1'b1}}});
        n_mag   = (r_q > n_lim) ? n_lim[VAL_W-1:0] : r_q[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= {n_un, {FRAC_BITS{1'b0}}};
                r_q    <= '0;
                r_rem  <= '0;
                r_ud   <= n_ud;
                r_neg  <= i_req.num[ACC_W-1] != i_req.den[ACC_W-1];
            end else if (r_busy) begin
                if (n_trial >= {1'b0, r_ud}) begin
                    r_rem <= ACC_W'(n_trial - {1'b0, r_ud});
                    r_q   <= {r_q[DIV_STEPS-2:0], 1'b1};
                end else begin
                    r_rem <= n_trial[ACC_W-1:0];
                    r_q   <= {r_q[DIV_STEPS-2:0], 1'b0};
                end
                r_dvd <= {r_dvd[DIV_STEPS-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? t_val'(-n_mag) : t_val'(n_mag);

endmodule

// ===== rtl/symmetric_iterative_solver_sd_cg_core.sv =====
// Fixed-point steepest descent / conjugate gradient solver for a symmetric
// system of up to 16 unknowns, signed Q16.16 values with saturating 64-bit
// accumulation. Load words (matrix lower triangle, right-hand side, start
// vector) are taken one per cycle while idle. A solve word starts the run;
// the block then takes no input until the last solution word has left.
// All multiplications and divisions go through one 32x32 multiply-accumulate
// unit and one bit-serial divider. Each iteration runs a matrix-vector
// product, dot products, the updates of solution and residual (plus the
// direction in conjugate gradient) and a divider run for each step size; the
// run then emits n words, one per cycle when the sink is ready. The solution
// stays stored, so a new solve continues from it. Registers: dimension at 0x0,
// max_iter at 0x4, algorithm at 0x8, stop_shift at 0xC.
module symmetric_iterative_solver_sd_cg_core
    import sisc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    sisc_in_if.sink           i_in,
    sisc_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [4:0] {
        S_IDLE, S_MV_RD, S_MV_MUL, S_MV_ACC, S_MV_WB,
        S_DOT_MUL, S_DOT_ACC, S_DOT_END, S_CHECK,
        S_DIV_GO, S_DIV_WAIT,
        S_UPD_MUL1, S_UPD_W1, S_UPD_MUL2, S_UPD_W2,
        S_DIR_MUL, S_DIR_W, S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        DOT_RR0, DOT_BB, DOT_DEN, DOT_NRR
    } t_dot;

    // configuration
    logic [DIM_W-1:0] r_dim;
    logic [7:0]       r_max_iter;
    logic             r_alg;
    logic [5:0]       r_shift;

    // sequencer
    t_state           r_state;
    t_dot             r_dot;
    logic             r_init;
    logic             r_beta_sel;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [7:0]       r_k;
    t_status          r_status;

    // scalars and vectors
    t_acc r_rr;
    t_acc r_thr;
    t_acc r_den;
    t_acc r_nrr;
    t_val r_alpha;
    t_val r_beta;
    t_val r_x [MAX_DIM];
    t_val r_b [MAX_DIM];
    t_val r_r [MAX_DIM];
    t_val r_d [MAX_DIM];
    t_val r_p [MAX_DIM];

    // matrix memory, symmetric entries stored once under (max, min)
    t_val             r_mem [2**MEM_AW];
    t_val             r_mdata;
    logic [MEM_AW-1:0] n_waddr;
    logic [MEM_AW-1:0] n_raddr;
    logic              n_mwe;

    t_mac_ctl         n_mac_ctl;
    t_val             n_mac_a;
    t_val             n_mac_b;
    t_acc             n_prod;
    t_acc             n_acc;
    t_div_req         n_div_req;
    t_div_rsp         n_div_rsp;

    logic             n_in_acc;
    logic             n_cfg_we;
    logic [DIM_W-1:0] n_dim;
    logic [IDX_W-1:0] n_last_idx;
    logic             n_last;
    t_val             n_y;
    t_acc             n_bb_shift;

    assign n_last_idx = IDX_W'(r_dim - DIM_W'(1));
    assign n_last     = r_i == n_last_idx;
    assign n_in_acc   = i_in.valid && i_in.ready;
    assign n_cfg_we   = psel && penable && pwrite;
    assign n_y        = q_scale(n_acc);
    assign n_bb_shift = t_acc'(n_acc >> r_shift);

    always_comb begin
        n_waddr = (i_in.row >= i_in.col) ? {i_in.row, i_in.col} : {i_in.col, i_in.row};
        n_raddr = (r_i >= r_j) ? {r_i, r_j} : {r_j, r_i};
        n_mwe   = n_in_acc && (t_action'(i_in.action) == ACT_MATRIX);
    end

    // matrix store with registered read
    always_ff @(posedge i_clk) begin
        if (n_mwe) begin
            r_mem[n_waddr] <= i_in.value;
        end
        r_mdata <= r_mem[n_raddr];
    end

    // operand select for the shared unit
    always_comb begin
        n_mac_a       = r_alpha;
        n_mac_b       = r_p[r_i];
        n_mac_ctl     = '0;
        n_div_req.start = r_state == S_DIV_GO;
        n_div_req.num = r_beta_sel ? r_nrr : r_rr;
        n_div_req.den = r_beta_sel ? r_rr : r_den;
        unique case (r_state)
            S_MV_MUL: begin
                n_mac_a = r_mdata;
                n_mac_b = r_init ? r_x[r_j] : (r_alg ? r_d[r_j] : r_r[r_j]);
            end
            S_MV_ACC, S_DOT_ACC: begin
                n_mac_ctl.acc_en = 1'b1;
            end
            S_MV_WB, S_DOT_END, S_IDLE: begin
                n_mac_ctl.acc_clr = 1'b1;
            end
            S_DOT_MUL: begin
                case (r_dot)
                    DOT_BB: begin
                        n_mac_a = r_b[r_i];
                        n_mac_b = r_b[r_i];
                    end
                    DOT_DEN: begin
                        n_mac_a = r_alg ? r_d[r_i] : r_r[r_i];
                        n_mac_b = r_p[r_i];
                    end
                    default: begin
                        n_mac_a = r_r[r_i];
                        n_mac_b = r_r[r_i];
                    end
                endcase
            end
            S_UPD_MUL1: begin
                n_mac_a = r_alpha;
                n_mac_b = r_alg ? r_d[r_i] : r_r[r_i];
            end
            S_UPD_MUL2: begin
                n_mac_a = r_alpha;
                n_mac_b = r_p[r_i];
            end
            S_DIR_MUL: begin
                n_mac_a = r_beta;
                n_mac_b = r_d[r_i];
            end
            default: begin
            end
        endcase
    end

    sisc_mac u_mac (
        .i_clk  (i_clk),
        .i_a    (n_mac_a),
        .i_b    (n_mac_b),
        .i_ctl  (n_mac_ctl),
        .o_prod (n_prod),
        .o_acc  (n_acc)
    );

    sisc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .o_rsp   (n_div_rsp)
    );

    // dimension write: zero ignored, clipped to the store size
    always_comb begin
        n_dim = pwdata[DIM_W-1:0];
        if (n_dim > DIM_W'(MAX_DIM)) begin
            n_dim = DIM_W'(MAX_DIM);
        end
    end

    // register readback
    always_comb begin
        unique case (t_reg'(paddr[3:2]))
            REG_DIMENSION:  prdata = 32'(r_dim);
            REG_MAX_ITER:   prdata = 32'(r_max_iter);
            REG_ALGORITHM:  prdata = 32'(r_alg);
            REG_STOP_SHIFT: prdata = 32'(r_shift);
            default:        prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // sequencer, stores and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim      <= DIM_W'(1);
            r_max_iter <= 8'd10;
            r_alg      <= 1'b1;
            r_shift    <= 6'd53;
            r_state    <= S_IDLE;
            r_dot      <= DOT_RR0;
            r_init     <= 1'b0;
            r_beta_sel <= 1'b0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_status   <= STAT_CONVERGED;
        end else begin
            if (n_cfg_we) begin
                unique case (t_reg'(paddr[3:2]))
                    REG_DIMENSION:  if (n_dim != '0) r_dim <= n_dim;
                    REG_MAX_ITER:   r_max_iter <= pwdata[7:0];
                    REG_ALGORITHM:  r_alg <= pwdata[0];
                    REG_STOP_SHIFT: r_shift <= pwdata[5:0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (n_in_acc) begin
                        case (t_action'(i_in.action))
                            ACT_RHS:       r_b[i_in.row] <= i_in.value;
                            ACT_START_VEC: r_x[i_in.row] <= i_in.value;
                            ACT_SOLVE: begin
                                r_init  <= 1'b1;
                                r_k     <= '0;
                                r_i     <= '0;
                                r_j     <= '0;
                                r_state <= S_MV_RD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MV_RD:  r_state <= S_MV_MUL;
                S_MV_MUL: r_state <= S_MV_ACC;
                S_MV_ACC: begin
                    if (r_j == n_last_idx) begin
                        r_j     <= '0;
                        r_state <= S_MV_WB;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_MV_RD;
                    end
                end
                S_MV_WB: begin
                    r_p[r_i] <= n_y;
                    if (r_init) begin
                        r_r[r_i] <= sat_val(t_acc'(r_b[r_i]) - t_acc'(n_y));
                        r_d[r_i] <= sat_val(t_acc'(r_b[r_i]) - t_acc'(n_y));
                    end
                    if (n_last) begin
                        r_i     <= '0;
                        r_dot   <= r_init ? DOT_RR0 : DOT_DEN;
                        r_state <= S_DOT_MUL;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_MV_RD;
                    end
                end
                S_DOT_MUL: r_state <= S_DOT_ACC;
                S_DOT_ACC: begin
                    if (n_last) begin
                        r_i     <= '0;
                        r_state <= S_DOT_END;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_DOT_MUL;
                    end
                end
                S_DOT_END: begin
                    unique case (r_dot)
                        DOT_RR0: begin
                            r_rr    <= n_acc;
                            r_dot   <= DOT_BB;
                            r_state <= S_DOT_MUL;
                        end
                        DOT_BB: begin
                            r_thr   <= n_bb_shift;
                            r_state <= S_CHECK;
                        end
                        DOT_DEN: begin
                            r_den <= n_acc;
                            if (n_acc == '0) begin
                                r_status <= STAT_BREAKDOWN;
                                r_state  <= S_EMIT;
                            end else begin
                                r_beta_sel <= 1'b0;
                                r_state    <= S_DIV_GO;
                            end
                        end
                        DOT_NRR: begin
                            r_nrr <= n_acc;
                            if (r_alg) begin
                                r_beta_sel <= 1'b1;
                                r_state    <= S_DIV_GO;
                            end else begin
                                r_rr    <= n_acc;
                                r_k     <= r_k + 1'b1;
                                r_state <= S_CHECK;
                            end
                        end
                        default: r_state <= S_CHECK;
                    endcase
                end
                S_CHECK: begin
                    if (r_rr <= r_thr) begin
                        r_status <= STAT_CONVERGED;
                        r_state  <= S_EMIT;
                    end else if (r_k >= r_max_iter) begin
                        r_status <= STAT_LIMIT;
                        r_state  <= S_EMIT;
                    end else begin
                        r_init  <= 1'b0;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= S_MV_RD;
                    end
                end
                S_DIV_GO: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (n_div_rsp.done) begin
                        r_i <= '0;
                        if (r_beta_sel) begin
                            r_beta  <= n_div_rsp.quo;
                            r_state <= S_DIR_MUL;
                        end else begin
                            r_alpha <= n_div_rsp.quo;
                            r_state <= S_UPD_MUL1;
                        end
                    end
                end
                S_UPD_MUL1: r_state <= S_UPD_W1;
                S_UPD_W1: begin
                    r_x[r_i] <= sat_val(t_acc'(r_x[r_i]) + t_acc'(q_scale(n_prod)));
                    r_state  <= S_UPD_MUL2;
                end
                S_UPD_MUL2: r_state <= S_UPD_W2;
                S_UPD_W2: begin
                    r_r[r_i] <= sat_val(t_acc'(r_r[r_i]) - t_acc'(q_scale(n_prod)));
                    if (n_last) begin
                        r_i     <= '0;
                        r_dot   <= DOT_NRR;
                        r_state <= S_DOT_MUL;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_UPD_MUL1;
                    end
                end
                S_DIR_MUL: r_state <= S_DIR_W;
                S_DIR_W: begin
                    r_d[r_i] <= sat_val(t_acc'(r_r[r_i]) + t_acc'(q_scale(n_prod)));
                    if (n_last) begin
                        r_i     <= '0;
                        r_rr    <= r_nrr;
                        r_k     <= r_k + 1'b1;
                        r_state <= S_CHECK;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_DIR_MUL;
                    end
                end
                S_EMIT: begin
                    if (o_out.ready) begin
                        if (n_last) begin
                            r_i     <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // handshake and output word
    assign i_in.ready       = r_state == S_IDLE;
    assign o_out.valid      = r_state == S_EMIT;
    assign o_out.index      = r_i;
    assign o_out.solution   = r_x[r_i];
    assign o_out.iterations = r_k;
    assign o_out.status     = r_status;
    assign o_out.last       = n_last;

endmodule

// ===== rtl/sisc_chk.sv =====
module sisc_chk
    import sisc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_last,
    input logic [1:0]       i_out_status,
    input logic [IDX_W-1:0] i_out_index,
    input logic [VAL_W-1:0] i_out_solution
);

    // no load is taken while a result word is offered
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> !i_out_valid)
        else $error("input ready while output valid");

    // a run keeps emitting until its last word
    a_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=> i_out_valid)
        else $error("result run broke off before last word");

    // after the last word the block is open for input again
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> i_in_ready)
        else $error("not ready after last word");

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_out_index) && $stable(i_out_solution) && $stable(i_out_status)))
        else $error("stalled output word changed");

endmodule

bind symmetric_iterative_solver_sd_cg_core sisc_chk u_sisc_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_last     (o_out.last),
    .i_out_status   (o_out.status),
    .i_out_index    (o_out.index),
    .i_out_solution (o_out.solution)
);
